@@ rtl/chse_pkg.sv @@
// ----------------------------------------------------------------------------
// chse_pkg
// Shared types, constants and search functions of the combination hash-sum
// engine.
// ----------------------------------------------------------------------------
package chse_pkg;

  localparam int unsigned HASH_W  = 64;
  localparam int unsigned IDX_W   = 6;   // card index, decks up to 64 cards
  localparam int unsigned SLOT_W  = 3;   // board size and slot pointer
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned CFG_W   = 3;

  localparam logic [HASH_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [HASH_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT = 33;

  localparam logic [SLOT_W-1:0] MIN_BOARD = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_LIMIT,
    ST_FILL,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } chse_state_e;

  // controller to datapath
  typedef struct packed {
    logic              start;   // latch free set, clear sums, hash the hole set
    logic              limit;   // find top position of slot ptr
    logic              fill;    // slot ptr = next free after slot ptr-1
    logic              adv;     // slot ptr = next free after itself
    logic              issue;   // hash the current board
    logic              finish;  // fold into total, load the result
    logic [SLOT_W-1:0] ptr;
  } chse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_done;
    logic found_last;
    logic pipe_busy;
  } chse_stat_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } chse_find_t;

  // lowest set bit
  function automatic chse_find_t find_first(logic [HASH_W-1:0] v);
    chse_find_t r;
    r = '0;
    for (int i = HASH_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(i);
      end
    end
    return r;
  endfunction

  // highest set bit
  function automatic chse_find_t find_last(logic [HASH_W-1:0] v);
    chse_find_t r;
    r = '0;
    for (int i = 0; i < HASH_W; i++) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/chse_mix.sv @@
// ----------------------------------------------------------------------------
// chse_mix
// Five-stage fmix64 pipeline, one request per cycle, tag carried alongside.
// ----------------------------------------------------------------------------
module chse_mix (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_tag_i,
  input  logic [chse_pkg::HASH_W-1:0] in_data_i,
  output logic                        out_valid_o,
  output logic                        out_tag_o,
  output logic [chse_pkg::HASH_W-1:0] out_data_o,
  output logic                        busy_o
);

  localparam int unsigned Stages = 5;

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] tag_q;

  logic [chse_pkg::HASH_W-1:0] a_q, b_q, res_q;
  logic [chse_pkg::HASH_W-1:0] pll1_q, pll2_q;
  logic [31:0]                 plh1_q, phl1_q, plh2_q, phl2_q;
  logic [chse_pkg::HASH_W-1:0] m1, m2;
  logic [31:0]                 cross1, cross2;

  // 64x64 low product from three 32x32 partial products
  assign cross1 = plh1_q + phl1_q;
  assign m1     = pll1_q + {cross1, 32'd0};
  assign cross2 = plh2_q + phl2_q;
  assign m2     = pll2_q + {cross2, 32'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      tag_q   <= '0;
    end else begin
      valid_q <= {valid_q[Stages-2:0], in_valid_i};
      tag_q   <= {tag_q[Stages-2:0], in_tag_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= in_data_i ^ (in_data_i >> chse_pkg::MIX_SHIFT);
    pll1_q <= 64'(a_q[31:0]) * 64'(chse_pkg::MIX_C1[31:0]);
    plh1_q <= a_q[31:0] * chse_pkg::MIX_C1[63:32];
    phl1_q <= a_q[63:32] * chse_pkg::MIX_C1[31:0];
    b_q    <= m1 ^ (m1 >> chse_pkg::MIX_SHIFT);
    pll2_q <= 64'(b_q[31:0]) * 64'(chse_pkg::MIX_C2[31:0]);
    plh2_q <= b_q[31:0] * chse_pkg::MIX_C2[63:32];
    phl2_q <= b_q[63:32] * chse_pkg::MIX_C2[31:0];
    res_q  <= m2 ^ (m2 >> chse_pkg::MIX_SHIFT);
  end

  assign out_valid_o = valid_q[Stages-1];
  assign out_tag_o   = tag_q[Stages-1];
  assign out_data_o  = res_q;
  assign busy_o      = |valid_q;

endmodule

@@ rtl/chse_dp.sv @@
// ----------------------------------------------------------------------------
// chse_dp
// Datapath: free-card set, board slots and their top positions, card search,
// hash pipeline, accumulators and result registers.
// ----------------------------------------------------------------------------
module chse_dp #(
  parameter int unsigned DECK_CARDS = 52,
  parameter int unsigned MAX_BOARD  = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  chse_pkg::chse_cmd_t                 cmd_i,
  input  logic [chse_pkg::SLOT_W-1:0]         k_last_i,
  input  logic [DECK_CARDS-1:0]               hole_cards_i,
  output chse_pkg::chse_stat_t                stat_o,
  output logic [MAX_BOARD-1:0]                at_max_o,
  output logic [chse_pkg::HASH_W-1:0]         set_sum_o,
  output logic [chse_pkg::COUNT_W-1:0]        board_count_o,
  output logic [chse_pkg::HASH_W-1:0]         running_total_o
);

  localparam int unsigned SidxW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
  localparam logic [chse_pkg::SLOT_W-1:0] LastSlot = chse_pkg::SLOT_W'(MAX_BOARD - 1);

  logic [chse_pkg::HASH_W-1:0]  free_q, hole_hash_q, set_acc_q, total_q;
  logic [chse_pkg::COUNT_W-1:0] count_q;
  logic [chse_pkg::IDX_W-1:0]   card_q [MAX_BOARD];
  logic [chse_pkg::IDX_W-1:0]   lim_q  [MAX_BOARD];
  logic [chse_pkg::HASH_W-1:0]  sum_out_q, total_out_q;
  logic [chse_pkg::COUNT_W-1:0] count_out_q;

  logic [DECK_CARDS-1:0]       free_deck;
  logic [chse_pkg::HASH_W-1:0] board_bits, above_mask, below_mask;
  logic [chse_pkg::HASH_W-1:0] first_src, last_src, mix_in;
  logic [chse_pkg::SLOT_W-1:0] from_slot, next_slot;
  logic [chse_pkg::IDX_W-1:0]  from_card, lim_next;
  chse_pkg::chse_find_t        first_hit, last_hit;

  logic                        mix_valid, mix_tag, mix_busy;
  logic [chse_pkg::HASH_W-1:0] mix_data;

  assign free_deck = ~hole_cards_i;

  // current board as a card mask
  always_comb begin
    board_bits = '0;
    for (int i = 0; i < MAX_BOARD; i++) begin
      if (chse_pkg::SLOT_W'(i) <= k_last_i) begin
        board_bits = board_bits | (64'd1 << card_q[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_BOARD; i++) begin
      at_max_o[i] = (card_q[i] == lim_q[i]);
    end
  end

  // next free card above a slot
  assign from_slot  = (cmd_i.adv || cmd_i.ptr == '0) ? cmd_i.ptr : cmd_i.ptr - 1'b1;
  assign from_card  = card_q[from_slot[SidxW-1:0]];
  assign above_mask = ~((64'd2 << from_card) - 64'd1);
  assign first_src  = (cmd_i.fill && cmd_i.ptr == '0) ? free_q : (free_q & above_mask);
  assign first_hit  = chse_pkg::find_first(first_src);

  // highest free card below the next slot's top, or any free card for the last slot
  assign next_slot  = (cmd_i.ptr >= LastSlot) ? LastSlot : cmd_i.ptr + 1'b1;
  assign lim_next   = lim_q[next_slot[SidxW-1:0]];
  assign below_mask = (64'd1 << lim_next) - 64'd1;
  assign last_src   = (cmd_i.ptr == k_last_i) ? free_q : (free_q & below_mask);
  assign last_hit   = chse_pkg::find_last(last_src);

  assign mix_in = cmd_i.start ? 64'(hole_cards_i) : (hole_hash_q ^ board_bits);

  chse_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.start | cmd_i.issue),
    .in_tag_i    (cmd_i.issue),
    .in_data_i   (mix_in),
    .out_valid_o (mix_valid),
    .out_tag_o   (mix_tag),
    .out_data_o  (mix_data),
    .busy_o      (mix_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.finish) begin
      total_q <= total_q + set_acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      free_q    <= 64'(free_deck);
      set_acc_q <= '0;
      count_q   <= '0;
    end else begin
      if (mix_valid && mix_tag) begin
        set_acc_q <= set_acc_q + mix_data;
      end
      if (cmd_i.issue) begin
        count_q <= count_q + 1'b1;
      end
    end
    if (mix_valid && !mix_tag) begin
      hole_hash_q <= mix_data;
    end
    if (cmd_i.fill || cmd_i.adv) begin
      card_q[cmd_i.ptr[SidxW-1:0]] <= first_hit.idx;
    end
    if (cmd_i.limit) begin
      lim_q[cmd_i.ptr[SidxW-1:0]] <= last_hit.idx;
    end
    if (cmd_i.finish) begin
      sum_out_q   <= set_acc_q;
      count_out_q <= count_q;
      total_out_q <= total_q + set_acc_q;
    end
  end

  assign stat_o.hash_done  = mix_valid && !mix_tag;
  assign stat_o.found_last = last_hit.found;
  assign stat_o.pipe_busy  = mix_busy;

  assign set_sum_o       = sum_out_q;
  assign board_count_o   = count_out_q;
  assign running_total_o = total_out_q;

endmodule

@@ rtl/chse_ctrl.sv @@
// ----------------------------------------------------------------------------
// chse_ctrl
// Controller: sequences hashing, slot setup, board walk and result handoff.
// ----------------------------------------------------------------------------
module chse_ctrl #(
  parameter int unsigned MAX_BOARD = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [chse_pkg::SLOT_W-1:0] k_last_i,
  input  chse_pkg::chse_stat_t        stat_i,
  input  logic [MAX_BOARD-1:0]        at_max_i,
  output chse_pkg::chse_cmd_t         cmd_o
);

  chse_pkg::chse_state_e       state_q, state_d;
  logic [chse_pkg::SLOT_W-1:0] ptr_q, ptr_d;
  logic                        out_valid_q, out_valid_d;
  logic [chse_pkg::SLOT_W-1:0] carry_slot;
  logic                        carry_found;

  // deepest slot below the last one that can still move up
  always_comb begin
    carry_slot  = '0;
    carry_found = 1'b0;
    for (int i = 0; i < MAX_BOARD - 1; i++) begin
      if (chse_pkg::SLOT_W'(i) < k_last_i && !at_max_i[i]) begin
        carry_slot  = chse_pkg::SLOT_W'(i);
        carry_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chse_pkg::ST_IDLE;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cmd_o       = '0;
    cmd_o.ptr   = ptr_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      chse_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = chse_pkg::ST_HASH;
        end
      end
      chse_pkg::ST_HASH: begin
        if (stat_i.hash_done) begin
          ptr_d   = k_last_i;
          state_d = chse_pkg::ST_LIMIT;
        end
      end
      chse_pkg::ST_LIMIT: begin
        cmd_o.limit = 1'b1;
        if (!stat_i.found_last) begin
          state_d = chse_pkg::ST_DRAIN;
        end else if (ptr_q == '0) begin
          state_d = chse_pkg::ST_FILL;
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end
      chse_pkg::ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (ptr_q == k_last_i) begin
          state_d = chse_pkg::ST_RUN;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      chse_pkg::ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (!at_max_i[k_last_i]) begin
          cmd_o.adv = 1'b1;
          cmd_o.ptr = k_last_i;
        end else if (carry_found) begin
          cmd_o.adv = 1'b1;
          cmd_o.ptr = carry_slot;
          ptr_d     = carry_slot + 1'b1;
          state_d   = chse_pkg::ST_FILL;
        end else begin
          state_d = chse_pkg::ST_DRAIN;
        end
      end
      chse_pkg::ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = chse_pkg::ST_DONE;
        end
      end
      chse_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = chse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = chse_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/combination_hash_sum_engine.sv @@
// ----------------------------------------------------------------------------
// combination_hash_sum_engine
// Hashes each hole set, then sums the fmix64 hash of every board drawn from
// the free cards, keeping a running total across sets.
// ----------------------------------------------------------------------------
// throughput: one request at a time, the next taken the cycle after the result
//   is loaded; the walk issues one board per cycle into the fmix64 pipeline,
//   except while slots refill after a carry
// reset: asynchronous active low; clears control, running total, board size 5
module combination_hash_sum_engine #(
  parameter int unsigned DECK_CARDS = 52,
  parameter int unsigned MAX_BOARD  = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [DECK_CARDS-1:0]        hole_cards_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [chse_pkg::HASH_W-1:0]  set_sum_o,
  output logic [chse_pkg::COUNT_W-1:0] board_count_o,
  output logic [chse_pkg::HASH_W-1:0]  running_total_o,
  // board size register
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [chse_pkg::CFG_W-1:0]   cfg_board_cards_i
);

  localparam logic [chse_pkg::SLOT_W-1:0] MaxK = chse_pkg::SLOT_W'(MAX_BOARD);

  logic [chse_pkg::CFG_W-1:0]  board_cards_q;
  logic [chse_pkg::SLOT_W-1:0] k_clamp, k_last;
  chse_pkg::chse_cmd_t         cmd;
  chse_pkg::chse_stat_t        stat;
  logic [MAX_BOARD-1:0]        at_max;

  // register writes are always taken, only while idle by contract
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_cards_q <= 3'd5;
    end else if (cfg_valid_i) begin
      board_cards_q <= cfg_board_cards_i;
    end
  end

  // board size held to the supported range
  always_comb begin
    if (board_cards_q < chse_pkg::MIN_BOARD) begin
      k_clamp = chse_pkg::MIN_BOARD;
    end else if (board_cards_q > MaxK) begin
      k_clamp = MaxK;
    end else begin
      k_clamp = board_cards_q;
    end
  end
  assign k_last = k_clamp - 1'b1;

  // sequencer: hash, slot tops, slot fill, board walk, drain, handoff
  chse_ctrl #(
    .MAX_BOARD (MAX_BOARD)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .k_last_i    (k_last),
    .stat_i      (stat),
    .at_max_i    (at_max),
    .cmd_o       (cmd)
  );

  // slots, card search, hash pipeline, sums, result registers
  chse_dp #(
    .DECK_CARDS (DECK_CARDS),
    .MAX_BOARD  (MAX_BOARD)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .k_last_i        (k_last),
    .hole_cards_i    (hole_cards_i),
    .stat_o          (stat),
    .at_max_o        (at_max),
    .set_sum_o       (set_sum_o),
    .board_count_o   (board_count_o),
    .running_total_o (running_total_o)
  );

  // no hash left in flight when a new request can be taken
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat.pipe_busy)
    else $error("hash pipeline busy while idle");

  // a set with no boards has a zero sum
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && board_count_o == '0) |-> set_sum_o == '0)
    else $error("nonzero sum with no boards");

  // handoff always presents a result on the next cycle
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("result lost at handoff");

  // setup, walk and handoff commands never overlap
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.limit, cmd.fill, cmd.issue, cmd.finish}))
    else $error("overlapping datapath commands");

endmodule

@@ bench/chse_sum_checker.sv @@
// ----------------------------------------------------------------------------
// chse_sum_checker
// Watches the request, result and board size channels of the combination
// hash-sum engine. It works out the per-set board hash sum, the board count
// and the running total for every accepted hole set, and compares each
// accepted result against the oldest outstanding one.
// ----------------------------------------------------------------------------
module chse_sum_checker #(
  parameter int unsigned DECK_CARDS = 52,
  parameter int unsigned MAX_BOARD  = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [DECK_CARDS-1:0]        hole_cards_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [chse_pkg::HASH_W-1:0]  set_sum_i,
  input  logic [chse_pkg::COUNT_W-1:0] board_count_i,
  input  logic [chse_pkg::HASH_W-1:0]  running_total_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [chse_pkg::CFG_W-1:0]   cfg_board_cards_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [chse_pkg::CFG_W-1:0] BOARD_AT_RESET = chse_pkg::CFG_W'(5);

  typedef struct packed {
    logic [chse_pkg::HASH_W-1:0]  set_sum;
    logic [chse_pkg::COUNT_W-1:0] board_count;
    logic [chse_pkg::HASH_W-1:0]  running_total;
  } set_result_t;

  set_result_t                 sums_due[$];
  logic [chse_pkg::CFG_W-1:0]  board_reg;
  logic [chse_pkg::HASH_W-1:0] total_acc;
  int                          err_n;
  int                          chk_n;

  function automatic logic [chse_pkg::HASH_W-1:0] fmix64(
    input logic [chse_pkg::HASH_W-1:0] x
  );
    x = x ^ (x >> chse_pkg::MIX_SHIFT);
    x = x * chse_pkg::MIX_C1;
    x = x ^ (x >> chse_pkg::MIX_SHIFT);
    x = x * chse_pkg::MIX_C2;
    x = x ^ (x >> chse_pkg::MIX_SHIFT);
    return x;
  endfunction

  // every k-card board out of the free cards, in lexicographic order
  function automatic set_result_t walk_boards(input logic [DECK_CARDS-1:0] hole, input int k);
    set_result_t                 r;
    int                          free_list[DECK_CARDS];
    int                          pos[MAX_BOARD];
    int                          n;
    int                          i;
    int                          j;
    logic [chse_pkg::HASH_W-1:0] seed;
    logic [chse_pkg::HASH_W-1:0] board;
    bit                          more;
    r    = '0;
    seed = fmix64(chse_pkg::HASH_W'(hole));
    n    = 0;
    for (int c = 0; c < DECK_CARDS; c++) begin
      if (!hole[c]) begin
        free_list[n] = c;
        n++;
      end
    end
    more = (n >= k);
    for (i = 0; i < k; i++) pos[i] = i;
    while (more) begin
      board = '0;
      for (i = 0; i < k; i++) board[free_list[pos[i]]] = 1'b1;
      r.set_sum     = r.set_sum + fmix64(seed ^ board);
      r.board_count = r.board_count + 1'b1;
      i = k - 1;
      while (i >= 0 && pos[i] == n - k + i) i--;
      if (i < 0) begin
        more = 1'b0;
      end else begin
        pos[i]++;
        for (j = i + 1; j < k; j++) pos[j] = pos[j-1] + 1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    set_result_t want;
    int          k;
    if (!rst_ni) begin
      board_reg = BOARD_AT_RESET;
      total_acc = '0;
      sums_due.delete();
      err_n     = 0;
      chk_n     = 0;
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (sums_due.size() == 0) begin
          err_n++;
          $error("result with no request outstanding: set_sum %h board_count %0d",
                 set_sum_i, board_count_i);
        end else begin
          want = sums_due.pop_front();
          if (set_sum_i !== want.set_sum) begin
            err_n++;
            $error("set_sum: expected %h, got %h", want.set_sum, set_sum_i);
          end
          if (board_count_i !== want.board_count) begin
            err_n++;
            $error("board_count: expected %0d, got %0d", want.board_count, board_count_i);
          end
          if (running_total_i !== want.running_total) begin
            err_n++;
            $error("running_total: expected %h, got %h", want.running_total, running_total_i);
          end
          chk_n++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) board_reg = cfg_board_cards_i;
      if (in_valid_i && in_ready_i) begin
        // out-of-range register codes clamp to the legal board sizes
        if (board_reg < chse_pkg::MIN_BOARD) k = int'(chse_pkg::MIN_BOARD);
        else if (board_reg > MAX_BOARD) k = int'(MAX_BOARD);
        else k = int'(board_reg);
        want               = walk_boards(hole_cards_i, k);
        total_acc          = total_acc + want.set_sum;
        want.running_total = total_acc;
        sums_due.push_back(want);
      end
      errors_o  <= err_n;
      pending_o <= sums_due.size();
      checked_o <= chk_n;
    end
  end

endmodule

@@ bench/tb_combination_hash_sum_engine.sv @@
// ----------------------------------------------------------------------------
// tb_combination_hash_sum_engine
// Drives hole-card sets and board size settings into the combination
// hash-sum engine, with random gaps and result back-pressure, while a
// separate checker predicts every board hash sum, board count and running
// total and compares them with what the engine returns.
// ----------------------------------------------------------------------------
module tb_combination_hash_sum_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DECK        = 52;
  localparam int unsigned MAX_CARDS   = 5;
  // long enough for two of the costliest sets to finish behind a held result
  localparam int unsigned HOLD_CYCLES = 100_000;
  // slowest legal run: every random set a 22-free five-card walk, plus the
  // all-free three-card walk and the long hold-off
  localparam int unsigned CYCLE_LIMIT = 15_000_000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 16;

  // board size register codes, the out-of-range ones included
  localparam logic [chse_pkg::CFG_W-1:0] BC_CODE0 = chse_pkg::CFG_W'(0);
  localparam logic [chse_pkg::CFG_W-1:0] BC_CODE1 = chse_pkg::CFG_W'(1);
  localparam logic [chse_pkg::CFG_W-1:0] BC_CODE2 = chse_pkg::CFG_W'(2);
  localparam logic [chse_pkg::CFG_W-1:0] BC_THREE = chse_pkg::CFG_W'(3);
  localparam logic [chse_pkg::CFG_W-1:0] BC_FOUR  = chse_pkg::CFG_W'(4);
  localparam logic [chse_pkg::CFG_W-1:0] BC_FIVE  = chse_pkg::CFG_W'(5);
  localparam logic [chse_pkg::CFG_W-1:0] BC_CODE6 = chse_pkg::CFG_W'(6);
  localparam logic [chse_pkg::CFG_W-1:0] BC_CODE7 = chse_pkg::CFG_W'(7);

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         in_valid        = 1'b0;
  logic [DECK-1:0]              hole_cards      = '0;
  logic                         out_ready       = 1'b0;
  logic                         cfg_valid       = 1'b0;
  logic [chse_pkg::CFG_W-1:0]   cfg_board_cards = '0;
  logic                         in_ready;
  logic                         out_valid;
  logic [chse_pkg::HASH_W-1:0]  set_sum;
  logic [chse_pkg::COUNT_W-1:0] board_count;
  logic [chse_pkg::HASH_W-1:0]  running_total;
  logic                         cfg_ready;

  int                           errors;
  int                           pending;
  int                           checked;

  // stimulus knobs and counters; hold_req and rx_idle drive the result sink
  logic                         hold_req = 1'b0;
  logic                         rx_idle  = 1'b0;
  bit                           tx_idle;
  int                           cur_k = 5;
  int                           items_sent;
  int                           starved;
  int unsigned                  cycle_count = 0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  combination_hash_sum_engine #(
    .DECK_CARDS (DECK),
    .MAX_BOARD  (MAX_CARDS)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .hole_cards_i      (hole_cards),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .set_sum_o         (set_sum),
    .board_count_o     (board_count),
    .running_total_o   (running_total),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_board_cards_i (cfg_board_cards)
  );

  chse_sum_checker #(
    .DECK_CARDS (DECK),
    .MAX_BOARD  (MAX_CARDS)
  ) checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .hole_cards_i      (hole_cards),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .set_sum_i         (set_sum),
    .board_count_i     (board_count),
    .running_total_i   (running_total),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_board_cards_i (cfg_board_cards),
    .errors_o          (errors),
    .pending_o         (pending),
    .checked_o         (checked)
  );

  // watchdog: a hung handshake ends the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // hole set with exactly n free cards at random places
  function automatic logic [DECK-1:0] hole_with_free(input int n);
    logic [DECK-1:0] m;
    int              idx;
    int              left;
    m    = '1;
    left = n;
    while (left > 0) begin
      idx = $urandom_range(0, DECK - 1);
      if (m[idx]) begin
        m[idx] = 1'b0;
        left--;
      end
    end
    return m;
  endfunction

  // hole set holding every card but a contiguous run starting at lo
  function automatic logic [DECK-1:0] hole_except(input int lo, input int cnt);
    logic [DECK-1:0] m;
    m = '1;
    for (int i = lo; i < lo + cnt; i++) m[i] = 1'b0;
    return m;
  endfunction

  // one request; valid stays up afterwards unless the next call idles first
  task automatic send_hole(input logic [DECK-1:0] m);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    hole_cards <= m;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
    if ($countones(~m) < cur_k) starved++;
  endtask

  // drop valid and wait until every result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // board size write, only ever with the engine idle
  task automatic write_board_cards(input logic [chse_pkg::CFG_W-1:0] code);
    settle();
    cfg_valid       <= 1'b1;
    cfg_board_cards <= code;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (code < chse_pkg::MIN_BOARD) cur_k = int'(chse_pkg::MIN_BOARD);
    else if (code > MAX_CARDS) cur_k = int'(MAX_CARDS);
    else cur_k = int'(code);
  endtask

  // result sink: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [DECK-1:0]            m;
    logic [chse_pkg::CFG_W-1:0] code;
    int                         sel;
    items_sent = 0;
    starved    = 0;
    tx_idle    = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: board size left at its reset value of 5
    send_hole('1);                       // no free cards at all
    send_hole(hole_with_free(4));        // one card short of a board
    send_hole(hole_except(0, 5));        // exactly one board, lowest cards
    send_hole(hole_except(DECK - 6, 6)); // top cards of the deck, six boards

    // smallest boards: the whole deck free, alternating card patterns, top three or two cards free
    write_board_cards(BC_THREE);
    send_hole('0);
    send_hole({13{4'h5}});
    send_hole({13{4'hA}});
    send_hole(hole_except(DECK - 3, 3));
    send_hole(hole_except(DECK - 2, 2));

    // codes below three behave as three
    write_board_cards(BC_CODE0);
    send_hole(hole_with_free(4));
    write_board_cards(BC_CODE1);
    send_hole(hole_with_free(5));
    write_board_cards(BC_CODE2);
    send_hole(hole_with_free(3));

    write_board_cards(BC_FOUR);
    send_hole(hole_with_free(4));
    send_hole(hole_with_free(9));

    // codes above five behave as five
    write_board_cards(BC_CODE7);
    send_hole(hole_with_free(7));
    send_hole(hole_with_free(5));
    write_board_cards(BC_CODE6);
    send_hole(hole_with_free(6));
    write_board_cards(BC_FIVE);
    send_hole(hole_with_free(8));

    // random phases, each with its own board size and idling mix
    for (int ph = 0; ph < PHASES; ph++) begin
      code = chse_pkg::CFG_W'($urandom_range(0, 7));
      write_board_cards(code);
      // last phase runs flat out on both sides
      tx_idle = (ph < PHASES - 1) && ($urandom_range(0, 2) != 0);
      rx_idle <= (ph < PHASES - 1) && ($urandom_range(0, 2) != 0);
      // one long result hold-off while requests keep coming, so the engine backs up
      if (ph == 0) hold_req <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          // occasional wide set, kept well below a full deck walk
          m = hole_with_free($urandom_range(15, 22));
        end else if (sel <= 2 && cur_k == 3) begin
          // raw random mask, affordable only for three-card boards
          m = DECK'({$urandom, $urandom});
        end else if (sel <= 4) begin
          // right around the too-few-cards boundary
          m = hole_with_free($urandom_range(cur_k - 1, cur_k + 1));
        end else begin
          m = hole_with_free($urandom_range(0, 13));
        end
        send_hole(m);
      end
    end

    // drain, then leave room for any stray result to show up
    settle();
    repeat (40) @(posedge clk_i);

    $display("covered %0d hole sets (%0d with too few free cards) over register codes 0 to 7,",
             items_sent, starved);
    $display("an all-free deck, a full hole set and a long result hold-off; %0d results checked",
             checked);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
